/* src/bbp_pkg.sv */
// bbp_pkg: shared types and constants of the buzzer beep pattern generator
`timescale 1ns / 1ps
package bbp_pkg;

  localparam int unsigned TimeW = 16;
  localparam int unsigned CntW  = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [1:0]       mode_t;
  typedef logic [TimeW-1:0] ms_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam mode_t MODE_OFF     = 2'd0;
  localparam mode_t MODE_ON      = 2'd1;
  localparam mode_t MODE_COUNTED = 2'd2;
  localparam mode_t MODE_ENDLESS = 2'd3;

  localparam cfg_idx_t CFG_MODE    = 2'd0;
  localparam cfg_idx_t CFG_ON_TIME = 2'd1;
  localparam cfg_idx_t CFG_CYCLE   = 2'd2;
  localparam cfg_idx_t CFG_REPEAT  = 2'd3;

  localparam ms_t TICK_MS = ms_t'(10);

endpackage

/* src/buzzer_beep_pattern_top.sv */
// buzzer_beep_pattern_top: beep pattern state machine with registered result word
// latency: a word accepted at one edge shows its result at the output from the next cycle
// throughput: one word per cycle if out_ready; update is a single 16 bit compare/add pass
// the result register frees in the same cycle it is taken, so input ready = !valid | ready
// reset (rst_n low, synchronous): mode off, elapsed time and repeats zero, tone silent,
//   all configuration registers zero, no result pending
`timescale 1ns / 1ps
module buzzer_beep_pattern_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  bbp_pkg::cfg_idx_t cfg_index,
  input  logic [15:0]     cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_restart,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_drive_on,
  output logic            out_tone_started,
  output bbp_pkg::mode_t  out_active_mode,
  output bbp_pkg::cnt_t   out_repeats_left
);
  import bbp_pkg::*;

  // configuration registers
  mode_t mode_setting_r;
  ms_t   on_time_r;
  ms_t   cycle_r;
  cnt_t  repeat_r;

  // pattern state
  mode_t mode_r, mode_nxt;
  ms_t   elapsed_r, elapsed_nxt;
  cnt_t  remain_r, remain_nxt;
  logic  sounding_r, sounding_nxt;
  logic  started_nxt;

  // result register
  logic  out_valid_r;
  logic  out_drive_r, out_started_r;
  mode_t out_mode_r;
  cnt_t  out_remain_r;

  logic  in_acc;
  cnt_t  remain_dec;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_setting_r <= MODE_OFF;
      on_time_r      <= '0;
      cycle_r        <= '0;
      repeat_r       <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE:    mode_setting_r <= mode_t'(cfg_data[1:0]);
        CFG_ON_TIME: on_time_r      <= cfg_data;
        CFG_CYCLE:   cycle_r        <= cfg_data;
        CFG_REPEAT:  repeat_r       <= cfg_data;
        default:     ;
      endcase
    end
  end

  assign remain_dec = (remain_r != '0) ? remain_r - cnt_t'(1) : '0;

  always_comb begin
    mode_nxt     = mode_r;
    elapsed_nxt  = elapsed_r;
    remain_nxt   = remain_r;
    sounding_nxt = sounding_r;
    started_nxt  = 1'b0;
    if (in_restart) begin
      mode_nxt    = mode_setting_r;
      remain_nxt  = repeat_r;
      elapsed_nxt = '0;
    end else begin
      unique case (mode_r)
        MODE_ON: begin
          started_nxt  = !sounding_r;
          sounding_nxt = 1'b1;
        end
        MODE_COUNTED, MODE_ENDLESS: begin
          if (elapsed_r < on_time_r) begin
            started_nxt  = !sounding_r;
            sounding_nxt = 1'b1;
          end else begin
            sounding_nxt = 1'b0;
          end
          if (elapsed_r >= cycle_r) begin
            elapsed_nxt = '0;
            if (mode_r == MODE_COUNTED) begin
              remain_nxt = remain_dec;
              // last cycle done: drop to off
              if (remain_dec == '0) begin
                mode_nxt     = MODE_OFF;
                sounding_nxt = 1'b0;
              end
            end
          end
        end
        default: begin
          sounding_nxt = 1'b0;
        end
      endcase
      elapsed_nxt = elapsed_nxt + TICK_MS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_OFF;
      elapsed_r   <= '0;
      remain_r    <= '0;
      sounding_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_r      <= mode_nxt;
        elapsed_r   <= elapsed_nxt;
        remain_r    <= remain_nxt;
        sounding_r  <= sounding_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_drive_r   <= sounding_nxt;
      out_started_r <= started_nxt;
      out_mode_r    <= mode_nxt;
      out_remain_r  <= remain_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_drive_on     = out_drive_r;
  assign out_tone_started = out_started_r;
  assign out_active_mode  = out_mode_r;
  assign out_repeats_left = out_remain_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result pending after reset");

  a_acc_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted word produced no result");

  a_restart_silent_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_restart |=> !out_tone_started && out_repeats_left == $past(repeat_r))
    else $error("restart word reported a tone start or wrong repeats");

  a_start_stop_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_started_r && !out_drive_r |-> out_mode_r == MODE_OFF)
    else $error("tone started and stopped without dropping to off");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_mode_r == mode_r && out_drive_r == sounding_r && out_remain_r == remain_r)
    else $error("result word out of step with state");

endmodule

/* dv/tb.sv */
// tb: self-checking testbench for the buzzer beep pattern generator
`timescale 1ns / 1ps
module tb;
  import bbp_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomWords = 1470;
  localparam int unsigned CalmTail    = 300;

  typedef struct packed {
    logic  drive_on;
    logic  tone_started;
    mode_t mode;
    cnt_t  repeats;
  } beep_word_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = CFG_MODE;
  logic [15:0] cfg_data = '0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  logic     in_restart = 1'b0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  logic     out_drive_on;
  logic     out_tone_started;
  mode_t    out_active_mode;
  cnt_t     out_repeats_left;

  buzzer_beep_pattern_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_drive_on     (out_drive_on),
    .out_tone_started (out_tone_started),
    .out_active_mode  (out_active_mode),
    .out_repeats_left (out_repeats_left)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadows and pattern state of the predictor
  mode_t reg_mode = MODE_OFF;
  ms_t   reg_on_time = '0;
  ms_t   reg_cycle = '0;
  cnt_t  reg_repeat = '0;

  mode_t beep_mode = MODE_OFF;
  ms_t   beep_elapsed = '0;
  cnt_t  beep_repeats = '0;
  logic  beep_sounding = 1'b0;

  beep_word_t  expected_beeps[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          idle_en = 1'b1;

  function automatic beep_word_t next_beep_word(logic restart);
    beep_word_t w;
    logic started;
    started = 1'b0;
    if (restart) begin
      beep_mode    = reg_mode;
      beep_repeats = reg_repeat;
      beep_elapsed = '0;
    end else begin
      case (beep_mode)
        MODE_ON: begin
          started       = !beep_sounding;
          beep_sounding = 1'b1;
        end
        MODE_COUNTED, MODE_ENDLESS: begin
          if (beep_elapsed < reg_on_time) begin
            started       = !beep_sounding;
            beep_sounding = 1'b1;
          end else begin
            beep_sounding = 1'b0;
          end
          if (beep_elapsed >= reg_cycle) begin
            beep_elapsed = '0;
            if (beep_mode == MODE_COUNTED) begin
              if (beep_repeats != '0) beep_repeats = beep_repeats - cnt_t'(1);
              // count exhausted: silence even if this tick just started the tone
              if (beep_repeats == '0) begin
                beep_mode     = MODE_OFF;
                beep_sounding = 1'b0;
              end
            end
          end
        end
        default: beep_sounding = 1'b0;
      endcase
      beep_elapsed = beep_elapsed + TICK_MS;
    end
    w.drive_on     = beep_sounding;
    w.tone_started = started;
    w.mode         = beep_mode;
    w.repeats      = beep_repeats;
    return w;
  endfunction

  task automatic report(string what, beep_word_t want, beep_word_t got);
    string want_s;
    string got_s;
    mismatches++;
    want_s = $sformatf("drive=%0b start=%0b mode=%0d repeats=%0d",
                       want.drive_on, want.tone_started, want.mode, want.repeats);
    got_s  = $sformatf("drive=%0b start=%0b mode=%0d repeats=%0d",
                       got.drive_on, got.tone_started, got.mode, got.repeats);
    if (mismatches <= 10)
      $display("%0t %s: expected %s, got %s", $time, what, want_s, got_s);
  endtask

  always @(posedge clk) begin
    beep_word_t got;
    beep_word_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_drive_on, out_tone_started, out_active_mode, out_repeats_left};
      if (expected_beeps.size() == 0) begin
        report("unexpected word", '0, got);
      end else begin
        want = expected_beeps.pop_front();
        if (got !== want) report("mismatch", want, got);
      end
    end
  end

  // result side back-pressure in bursts
  int unsigned stall_left = 0;
  always @(negedge clk) begin
    if (idle_en && stall_left == 0 && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 6);
    if (idle_en && stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_word(logic restart);
    int unsigned gap;
    gap = (idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    expected_beeps.push_back(next_beep_word(restart));
  endtask

  task automatic ticks(int unsigned n);
    repeat (n) send_word(1'b0);
  endtask

  // stop sending and wait until every result is back
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (expected_beeps.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MODE:    reg_mode    = mode_t'(data);
      CFG_ON_TIME: reg_on_time = data;
      CFG_CYCLE:   reg_cycle   = data;
      default:     reg_repeat  = data;
    endcase
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic set_pattern(mode_t mode, ms_t on_time, ms_t cycle, cnt_t repeats);
    drain();
    write_reg(CFG_MODE, 16'(mode));
    write_reg(CFG_ON_TIME, on_time);
    write_reg(CFG_CYCLE, cycle);
    write_reg(CFG_REPEAT, repeats);
  endtask

  task automatic test_after_reset();
    ticks(2);
    send_word(1'b1);
    ticks(1);
  endtask

  task automatic test_always_on();
    set_pattern(MODE_ON, 16'd0, 16'd0, 16'd0);
    send_word(1'b1);
    ticks(3);
    // restart while sounding keeps the tone and reports no start
    send_word(1'b1);
    ticks(1);
  endtask

  task automatic test_counted_alarm();
    set_pattern(MODE_COUNTED, 16'd20, 16'd30, 16'd2);
    send_word(1'b1);
    ticks(10);
  endtask

  task automatic test_start_stop_same_tick();
    set_pattern(MODE_COUNTED, 16'd10, 16'd0, 16'd1);
    send_word(1'b1);
    ticks(2);
  endtask

  task automatic test_zero_repeats();
    set_pattern(MODE_COUNTED, 16'd10, 16'd20, 16'd0);
    send_word(1'b1);
    ticks(4);
  endtask

  task automatic test_register_extremes();
    // zero cycle length: every tick ends a cycle
    set_pattern(MODE_ENDLESS, 16'hFFFF, 16'd0, 16'hFFFF);
    send_word(1'b1);
    ticks(3);
    set_pattern(MODE_COUNTED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(1'b1);
    ticks(2);
  endtask

  task automatic test_long_cycle();
    // cycle far longer than the on window: two sounding ticks, then a long quiet stretch
    set_pattern(MODE_ENDLESS, 16'd20, 16'hFFFF, 16'd0);
    send_word(1'b1);
    ticks(40);
  endtask

  function automatic ms_t pick_ms(int unsigned span);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return ms_t'($urandom);
      default: return ms_t'($urandom_range(0, span));
    endcase
  endfunction

  task automatic test_random_patterns();
    int unsigned sent;
    int unsigned burst;
    cnt_t        repeats;
    sent = 0;
    while (sent < RandomWords) begin
      if (sent + CalmTail >= RandomWords) idle_en = 1'b0;
      case ($urandom_range(0, 7))
        0:       repeats = '0;
        1:       repeats = 16'hFFFF;
        2:       repeats = cnt_t'($urandom);
        default: repeats = cnt_t'($urandom_range(1, 6));
      endcase
      drain();
      if ($urandom_range(0, 3) != 0) write_reg(CFG_MODE, 16'($urandom_range(0, 3)));
      if ($urandom_range(0, 3) != 0) write_reg(CFG_ON_TIME, pick_ms(120));
      if ($urandom_range(0, 3) != 0) write_reg(CFG_CYCLE, pick_ms(200));
      write_reg(CFG_REPEAT, repeats);
      burst = $urandom_range(20, 60);
      send_word(1'b1);
      repeat (burst - 1) send_word($urandom_range(0, 15) == 0);
      sent += burst;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_after_reset();
    test_always_on();
    test_counted_alarm();
    test_start_stop_same_tick();
    test_zero_repeats();
    test_register_extremes();
    test_long_cycle();
    test_random_patterns();
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_beeps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* buzzer_beep_pattern_top.f */
src/bbp_pkg.sv
src/buzzer_beep_pattern_top.sv
dv/tb.sv
